// ----- sv/olfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olfr_pkg: shared types for the ordered list find/remove unit
// Operation, status and sequencer codes, plus the fixed field widths.
// ----------------------------------------------------------------------------
package olfr_pkg;

    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int FILL_W   = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_READ   = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

endpackage

// ----- sv/olfr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olfr_if: request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface olfr_req_if;
    logic                         valid;
    logic                         ready;
    logic [olfr_pkg::MODE_W-1:0]  mode;
    logic [olfr_pkg::VALUE_W-1:0] value;
    logic [olfr_pkg::POS_W-1:0]   position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface olfr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [olfr_pkg::STATUS_W-1:0] status;
    logic [olfr_pkg::INDEX_W-1:0]  found_index;
    logic [olfr_pkg::VALUE_W-1:0]  read_value;
    logic [olfr_pkg::FILL_W-1:0]   fill_count;

    modport source (output valid, output status, output found_index, output read_value,
                    output fill_count, input ready);
    modport sink   (input valid, input status, input found_index, input read_value,
                    input fill_count, output ready);
endinterface

// ----- sv/ordered_list_find_remove_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_find_remove_unit: fixed-capacity ordered list with linear search
// Append, read at index, find first and remove first over a list memory with
// one read and one write port, driven by a small sequencer.
// ----------------------------------------------------------------------------
// One request word is taken at a time; req.ready is low until its response is
// loaded into the output register. All list traffic goes through the one read
// and one write port of the entry memory, one entry per cycle, and that sets
// the timing: append, a full list or an index out of range go from acceptance
// straight to S_FINISH, a read passes through S_RDWAIT first. Find examines
// entries one by one from the start position in S_SCAN; remove then moves each
// later entry down in S_SHIFT, or skips the moves when the match is the last
// entry. The next request can be taken while the previous response still
// waits to be collected. There is no clearing pass after reset.
module ordered_list_find_remove_unit #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    olfr_req_if.sink   req,
    olfr_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > olfr_pkg::POS_W) ? CNT_W : olfr_pkg::POS_W;

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;

    olfr_pkg::state_t      state_reg,      state_next;
    logic [CNT_W-1:0]      count_reg,      count_next;
    logic [CNT_W-1:0]      idx_reg,        idx_next;
    logic [CNT_W-1:0]      cmp_idx_reg,    cmp_idx_next;
    logic                  pend_reg,       pend_next;
    logic                  remove_reg,     remove_next;
    logic                  inc_reg,        inc_next;
    logic                  dec_reg,        dec_next;
    logic [WORD_WIDTH-1:0] word_reg,       word_next;
    olfr_pkg::status_t     res_status_reg, res_status_next;
    logic [CNT_W-1:0]      res_index_reg,  res_index_next;
    logic [WORD_WIDTH-1:0] res_data_reg,   res_data_next;

    logic                            out_valid_reg,  out_valid_next;
    logic [olfr_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [olfr_pkg::INDEX_W-1:0]    out_index_reg,  out_index_next;
    logic [olfr_pkg::VALUE_W-1:0]    out_data_reg,   out_data_next;
    logic [olfr_pkg::FILL_W-1:0]     out_fill_reg,   out_fill_next;

    logic                  req_fire;
    logic                  pos_beyond;
    logic                  list_full;
    logic                  match;
    logic [WORD_WIDTH-1:0] req_word;

    assign req.ready   = (state_reg == olfr_pkg::S_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign req_word    = WORD_WIDTH'(req.value);
    assign pos_beyond  = CMP_W'(req.position) >= CMP_W'(count_reg);
    assign list_full   = (count_reg == CNT_W'(DEPTH));
    assign match       = pend_reg && (rd_data_reg == word_reg);
    assign mem_raddr   = (state_reg == olfr_pkg::S_IDLE) ? IDX_W'(req.position)
                                                         : idx_reg[IDX_W-1:0];

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_index = out_index_reg;
    assign rsp.read_value  = out_data_reg;
    assign rsp.fill_count  = out_fill_reg;

    // entry memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olfr_pkg::S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            remove_reg    <= 1'b0;
            inc_reg       <= 1'b0;
            dec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            remove_reg    <= remove_next;
            inc_reg       <= inc_next;
            dec_reg       <= dec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        word_reg       <= word_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_data_reg   <= out_data_next;
        out_fill_reg   <= out_fill_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_next       = pend_reg;
        remove_next     = remove_reg;
        inc_next        = inc_reg;
        dec_next        = dec_reg;
        word_next       = word_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_data_next   = out_data_reg;
        out_fill_next   = out_fill_reg;
        mem_we          = 1'b0;
        mem_waddr       = cmp_idx_reg[IDX_W-1:0];
        mem_wdata       = rd_data_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            olfr_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    word_next       = req_word;
                    res_status_next = olfr_pkg::STAT_OK;
                    res_index_next  = '0;
                    res_data_next   = '0;
                    inc_next        = 1'b0;
                    dec_next        = 1'b0;
                    remove_next     = (olfr_pkg::mode_t'(req.mode) == olfr_pkg::MODE_REMOVE);
                    case (olfr_pkg::mode_t'(req.mode))
                        olfr_pkg::MODE_APPEND:
                        begin
                            if (list_full)
                            begin
                                res_status_next = olfr_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = count_reg[IDX_W-1:0];
                                mem_wdata = req_word;
                                inc_next  = 1'b1;
                            end
                            state_next = olfr_pkg::S_FINISH;
                        end
                        olfr_pkg::MODE_READ:
                        begin
                            if (pos_beyond)
                            begin
                                res_status_next = olfr_pkg::STAT_RANGE;
                                state_next      = olfr_pkg::S_FINISH;
                            end
                            else
                            begin
                                state_next = olfr_pkg::S_RDWAIT;
                            end
                        end
                        default:
                        begin
                            if (pos_beyond)
                            begin
                                res_status_next = olfr_pkg::STAT_NOT_FOUND;
                                state_next      = olfr_pkg::S_FINISH;
                            end
                            else
                            begin
                                idx_next   = CNT_W'(req.position);
                                pend_next  = 1'b0;
                                state_next = olfr_pkg::S_SCAN;
                            end
                        end
                    endcase
                end
            end

            olfr_pkg::S_RDWAIT:
            begin
                res_data_next = rd_data_reg;
                state_next    = olfr_pkg::S_FINISH;
            end

            // one entry compared per cycle, read issued one ahead
            olfr_pkg::S_SCAN:
            begin
                if (match)
                begin
                    res_index_next = cmp_idx_reg;
                    pend_next      = 1'b0;
                    state_next     = remove_reg ? olfr_pkg::S_SHIFT : olfr_pkg::S_FINISH;
                end
                else if (idx_reg == count_reg)
                begin
                    res_status_next = olfr_pkg::STAT_NOT_FOUND;
                    pend_next       = 1'b0;
                    state_next      = olfr_pkg::S_FINISH;
                end
                else
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_reg;
                    idx_next     = idx_reg + CNT_W'(1);
                end
            end

            // move later entries down; cmp_idx is the write slot, idx the read slot
            olfr_pkg::S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we       = 1'b1;
                    cmp_idx_next = cmp_idx_reg + CNT_W'(1);
                end
                if (idx_reg != count_reg)
                begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        dec_next   = 1'b1;
                        state_next = olfr_pkg::S_FINISH;
                    end
                end
            end

            olfr_pkg::S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    if (inc_reg)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (dec_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = olfr_pkg::INDEX_W'(res_index_reg);
                    out_data_next   = olfr_pkg::VALUE_W'(res_data_reg);
                    out_fill_next   = olfr_pkg::FILL_W'(count_next);
                    inc_next        = 1'b0;
                    dec_next        = 1'b0;
                    state_next      = olfr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = olfr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/olfr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olfr_checker: port-level checks for the ordered list unit
// Watches the request and response channels only; bound to ordered_list_find_remove_unit.
// ----------------------------------------------------------------------------
module olfr_checker #(
    parameter int DEPTH = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [olfr_pkg::STATUS_W-1:0] rsp_status,
    input logic [olfr_pkg::INDEX_W-1:0]  rsp_found_index,
    input logic [olfr_pkg::VALUE_W-1:0]  rsp_read_value,
    input logic [olfr_pkg::FILL_W-1:0]   rsp_fill_count
);

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_found_index) && $stable(rsp_read_value)
            && $stable(rsp_fill_count))
        else $error("response word changed while stalled");

    // one request in flight
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == olfr_pkg::STAT_FULL)
            |-> rsp_fill_count == olfr_pkg::FILL_W'(DEPTH))
        else $error("list full reported below capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != olfr_pkg::STAT_OK)
            |-> (rsp_found_index == '0) && (rsp_read_value == '0))
        else $error("failed request returned data");

endmodule

bind ordered_list_find_remove_unit olfr_checker #(.DEPTH(DEPTH)) u_olfr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found_index (rsp.found_index),
    .rsp_read_value  (rsp.read_value),
    .rsp_fill_count  (rsp.fill_count)
);

// ----- test/ordered_list_find_remove_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_find_remove_unit_tb: self-checking bench for the list unit
// Sends append, read, find and remove words with random idling on both
// channels. A behavioural copy of the list predicts every response word, and
// each response is compared field by field, in order, with its prediction.
// ----------------------------------------------------------------------------
module ordered_list_find_remove_unit_tb;

    localparam int DEPTH = 64;

    typedef struct packed {
        olfr_pkg::status_t            status;
        logic [olfr_pkg::INDEX_W-1:0] found_index;
        logic [olfr_pkg::VALUE_W-1:0] read_value;
        logic [olfr_pkg::FILL_W-1:0]  fill_count;
    } list_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    olfr_req_if req ();
    olfr_rsp_if rsp ();

    ordered_list_find_remove_unit #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (olfr_pkg::VALUE_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [olfr_pkg::VALUE_W-1:0] list_words [DEPTH];
    int                           list_fill = 0;
    list_reply_t                  pending_replies [$];
    int                           error_count = 0;
    bit                           idling = 1'b1;
    int                           rsp_stall = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Behavioural list: updates the copy and returns the expected response.
    function automatic list_reply_t apply_list_op(input olfr_pkg::mode_t op,
                                                  input logic [olfr_pkg::VALUE_W-1:0] word,
                                                  input logic [olfr_pkg::POS_W-1:0] pos);
        list_reply_t r;
        int          hit;
        r        = '0;
        r.status = olfr_pkg::STAT_OK;
        hit      = -1;
        case (op)
            olfr_pkg::MODE_APPEND:
            begin
                if (list_fill >= DEPTH)
                    r.status = olfr_pkg::STAT_FULL;
                else
                begin
                    list_words[list_fill] = word;
                    list_fill++;
                end
            end
            olfr_pkg::MODE_READ:
            begin
                if (int'(pos) >= list_fill)
                    r.status = olfr_pkg::STAT_RANGE;
                else
                    r.read_value = list_words[pos];
            end
            default:
            begin
                for (int i = int'(pos); i < list_fill; i++)
                    if (hit < 0 && list_words[i] == word)
                        hit = i;
                if (hit < 0)
                    r.status = olfr_pkg::STAT_NOT_FOUND;
                else
                begin
                    r.found_index = hit[olfr_pkg::INDEX_W-1:0];
                    if (op == olfr_pkg::MODE_REMOVE)
                    begin
                        for (int i = hit; i < list_fill - 1; i++)
                            list_words[i] = list_words[i + 1];
                        list_fill--;
                    end
                end
            end
        endcase
        r.fill_count = list_fill[olfr_pkg::FILL_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_reply();
        list_reply_t want;
        if (pending_replies.size() == 0)
        begin
            report_mismatch("response word with nothing expected");
            return;
        end
        want = pending_replies.pop_front();
        if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
        if (rsp.found_index !== want.found_index)
            report_mismatch($sformatf("found_index %0d, expected %0d",
                                      rsp.found_index, want.found_index));
        if (rsp.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      rsp.read_value, want.read_value));
        if (rsp.fill_count !== want.fill_count)
            report_mismatch($sformatf("fill_count %0d, expected %0d",
                                      rsp.fill_count, want.fill_count));
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            check_reply();
    end

    // Response back-pressure in random bursts, started only while idling is set.
    always @(posedge clk)
    begin
        if (rsp_stall > 0)
        begin
            rsp_stall--;
            rsp.ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            rsp_stall = $urandom_range(0, 15);
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    task automatic send_word(input olfr_pkg::mode_t op,
                             input logic [olfr_pkg::VALUE_W-1:0] word,
                             input logic [olfr_pkg::POS_W-1:0] pos);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.mode     <= op;
        req.value    <= word;
        req.position <= pos;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        pending_replies.push_back(apply_list_op(op, word, pos));
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [olfr_pkg::POS_W-1:0] any_position();
        return olfr_pkg::POS_W'($urandom_range(0, DEPTH - 1));
    endfunction

    // Small values repeat often so that duplicates and hits are common.
    function automatic logic [olfr_pkg::VALUE_W-1:0] fresh_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return $urandom_range(0, 15);
        if (roll == 4)
            return '1;
        return $urandom();
    endfunction

    function automatic logic [olfr_pkg::VALUE_W-1:0] search_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (list_fill > 0 && roll < 6)
            return list_words[$urandom_range(0, list_fill - 1)];
        if (roll < 8)
            return $urandom_range(0, 15);
        return $urandom();
    endfunction

    function automatic logic [olfr_pkg::POS_W-1:0] start_position();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return '0;
        if (roll < 8 && list_fill > 0)
            return olfr_pkg::POS_W'($urandom_range(0, list_fill - 1));
        return any_position();
    endfunction

    function automatic logic [olfr_pkg::POS_W-1:0] read_position();
        if (list_fill > 0 && $urandom_range(0, 9) < 8)
            return olfr_pkg::POS_W'($urandom_range(0, list_fill - 1));
        return any_position();
    endfunction

    task automatic random_op(input int w_append, input int w_read, input int w_find);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < w_append)
            send_word(olfr_pkg::MODE_APPEND, fresh_word(), any_position());
        else if (roll < w_append + w_read)
            send_word(olfr_pkg::MODE_READ, $urandom(), read_position());
        else if (roll < w_append + w_read + w_find)
            send_word(olfr_pkg::MODE_FIND, search_word(), start_position());
        else
            send_word(olfr_pkg::MODE_REMOVE, search_word(), start_position());
    endtask

    task automatic test_empty_list();
        send_word(olfr_pkg::MODE_READ, '0, '0);
        send_word(olfr_pkg::MODE_READ, '1, 6'd63);
        send_word(olfr_pkg::MODE_FIND, '0, '0);
        send_word(olfr_pkg::MODE_REMOVE, '1, 6'd63);
        wait_drained();
    endtask

    task automatic test_append_read();
        send_word(olfr_pkg::MODE_APPEND, '0, 6'd63);
        send_word(olfr_pkg::MODE_APPEND, '1, '0);
        send_word(olfr_pkg::MODE_APPEND, 32'd5, 6'd63);
        send_word(olfr_pkg::MODE_APPEND, '0, 6'd21);
        send_word(olfr_pkg::MODE_APPEND, 32'd5, 6'd42);
        for (int i = 0; i < 5; i++)
            send_word(olfr_pkg::MODE_READ, $urandom(), olfr_pkg::POS_W'(i));
        send_word(olfr_pkg::MODE_READ, '0, 6'd5);
        send_word(olfr_pkg::MODE_READ, '1, 6'd63);
        wait_drained();
    endtask

    // List is now 0, all ones, 5, 0, 5.
    task automatic test_find_remove();
        send_word(olfr_pkg::MODE_FIND, 32'd5, '0);
        send_word(olfr_pkg::MODE_FIND, 32'd5, 6'd3);
        send_word(olfr_pkg::MODE_FIND, '0, 6'd1);
        send_word(olfr_pkg::MODE_FIND, 32'd7, '0);
        send_word(olfr_pkg::MODE_FIND, '0, 6'd5);
        send_word(olfr_pkg::MODE_REMOVE, '0, '0);
        send_word(olfr_pkg::MODE_REMOVE, 32'd5, 6'd2);
        send_word(olfr_pkg::MODE_REMOVE, 32'd9, '0);
        send_word(olfr_pkg::MODE_READ, '0, '0);
        wait_drained();
    endtask

    task automatic test_fill_and_drain();
        int idx;
        repeat (2)
        begin
            while (list_fill < DEPTH)
                send_word(olfr_pkg::MODE_APPEND, fresh_word(), any_position());
            repeat (3)
                send_word(olfr_pkg::MODE_APPEND, fresh_word(), any_position());
            send_word(olfr_pkg::MODE_READ, $urandom(), 6'd63);
            send_word(olfr_pkg::MODE_FIND, list_words[DEPTH - 1], 6'd63);
            repeat (6)
                random_op(0, 30, 40);
            wait_drained();
            while (list_fill > 0)
            begin
                idx = $urandom_range(0, list_fill - 1);
                if ($urandom_range(0, 3) == 0)
                    send_word(olfr_pkg::MODE_REMOVE, list_words[idx], any_position());
                else
                    send_word(olfr_pkg::MODE_REMOVE, list_words[idx], '0);
            end
            send_word(olfr_pkg::MODE_READ, $urandom(), '0);
            send_word(olfr_pkg::MODE_FIND, $urandom(), '0);
        end
        wait_drained();
    endtask

    task automatic test_random_mixed();
        idling = 1'b1;
        for (int seg = 0; seg < 10; seg++)
        begin
            repeat (85)
            begin
                case (seg % 3)
                    0:       random_op(55, 15, 15);
                    1:       random_op(10, 15, 15);
                    default: random_op(30, 20, 20);
                endcase
            end
            if (seg == 4)
                wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_back_to_back();
        idling = 1'b0;
        repeat (200)
            random_op(35, 20, 20);
        wait_drained();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.mode     = olfr_pkg::MODE_APPEND;
        req.value    = '0;
        req.position = '0;
        rsp.ready    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_append_read();
        test_find_remove();
        test_fill_and_drain();
        test_random_mixed();
        test_back_to_back();

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("[ordered_list_find_remove_unit] OK");
        else
            $display("[ordered_list_find_remove_unit] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[ordered_list_find_remove_unit] ERROR");
        $finish;
    end

endmodule
